// File: rtl/hca_pkg.sv
// ============================================================================
// hca_pkg: shared types and constants for the humidity calibration pipeline
// Field widths, register codes and the payload records that move between
// the front end, the divider steps and the finishing stages.
// ============================================================================
`default_nettype none

package hca_pkg;

  localparam int RAW_W   = 16;            // raw sample and raw calibration points
  localparam int HUM_W   = 8;             // humidity in half-percent units
  localparam int DIFF_W  = RAW_W + 1;     // difference of two raw words
  localparam int DH_W    = HUM_W + 1;     // difference of two humidity points
  localparam int PROD_W  = DIFF_W + DH_W; // signed numerator
  localparam int MAG_W   = 24;            // |numerator| <= 65535 * 255
  localparam int DEN_W   = RAW_W;         // |denominator| <= 65535
  localparam int QBITS   = 9;             // quotient bits kept (|q| < 512)
  localparam int DIG_W   = 6;
  localparam int LATENCY = 8;             // accepted sample to result strobe

  localparam logic [HUM_W-1:0] HUM_MAX    = 8'd200;
  localparam logic [DIG_W-1:0] ASCII_ZERO = 6'd48;

  // configuration register indexes
  localparam logic [1:0] REG_LO_HUM = 2'd0;
  localparam logic [1:0] REG_HI_HUM = 2'd1;
  localparam logic [1:0] REG_LO_RAW = 2'd2;
  localparam logic [1:0] REG_HI_RAW = 2'd3;

  // divider record: magnitudes, partial quotient and side flags
  typedef struct packed {
    logic [MAG_W-1:0] rem;
    logic [QBITS-1:0] quo;
    logic [DEN_W-1:0] den_mag;
    logic             neg;     // quotient is negative
    logic             ovf;     // |quotient| >= 512; result clamps unless dz is set
    logic             dz;      // calibration raw points equal
    logic [HUM_W-1:0] h0;
  } div_t;

  // finished result
  typedef struct packed {
    logic [HUM_W-1:0] hum;
    logic [DIG_W-1:0] d_thou;
    logic [DIG_W-1:0] d_hund;
    logic [DIG_W-1:0] d_tens;
    logic [DIG_W-1:0] d_ones;
    logic             clamped;
    logic             dz;
  } res_t;

endpackage

`default_nettype wire

// File: rtl/humidity_calibrate_to_ascii.sv
// ============================================================================
// humidity_calibrate_to_ascii: two-point humidity calibration to ASCII
// Maps a raw signed 16-bit sample through the line between two calibration
// points, clamps to 0..200 half-percent and emits four ASCII digits.
// ============================================================================
//
//   channel  | handshake              | payload
//   ---------+------------------------+-------------------------------------
//   input    | start / busy           | in_raw_sample
//   result   | out_valid (strobe)     | out_humidity_half_pct, out_digit_*,
//            |                        | out_was_clamped, out_divide_error
//   config   | psel/penable/pwrite    | paddr, pwdata, prdata (APB style)
//
// Cycles: a sample transfers on any cycle with start high; busy is always
// low, so one sample per clock is sustained. Its result strobes out_valid
// once it has passed the 8 stages: difference, 17x9 multiply, magnitude
// split and range check, three divider slices of 3 quotient bits each,
// sign/offset/clamp, decimal split.
// Reset: synchronous, active low; clears the stage valid bits and all four
// calibration registers to 0. Results cannot be held off by the receiver.
//
`default_nettype none

module humidity_calibrate_to_ascii import hca_pkg::*; (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  // input channel
  input  wire logic                    start,
  output logic                         busy,
  input  wire logic signed [RAW_W-1:0] in_raw_sample,
  // result channel
  output logic                         out_valid,
  output logic        [HUM_W-1:0]      out_humidity_half_pct,
  output logic        [DIG_W-1:0]      out_digit_thousands,
  output logic        [DIG_W-1:0]      out_digit_hundreds,
  output logic        [DIG_W-1:0]      out_digit_tens,
  output logic        [DIG_W-1:0]      out_digit_ones,
  output logic                         out_was_clamped,
  output logic                         out_divide_error,
  // configuration port
  input  wire logic                    psel,
  input  wire logic                    penable,
  input  wire logic                    pwrite,
  input  wire logic [3:0]              paddr,
  input  wire logic [31:0]             pwdata,
  output logic      [31:0]             prdata,
  output logic                         pready
);

  // calibration registers
  logic        [HUM_W-1:0] lo_hum_r;
  logic        [HUM_W-1:0] hi_hum_r;
  logic signed [RAW_W-1:0] lo_raw_r;
  logic signed [RAW_W-1:0] hi_raw_r;
  logic                    wr_en;
  logic        [1:0]       reg_idx;

  // pipeline links
  logic in_xfer;
  logic fv;
  div_t fd;
  logic v_a, v_b, v_c;
  div_t d_a, d_b, d_c;
  logic rv;
  res_t rr;

  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign wr_en   = psel & penable & pwrite & pready;

  // the user must change the registers only while no sample is in flight; the block itself does not enforce this
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lo_hum_r <= '0;
      hi_hum_r <= '0;
      lo_raw_r <= '0;
      hi_raw_r <= '0;
    end else if (wr_en) begin
      case (reg_idx)
        REG_LO_HUM: lo_hum_r <= pwdata[HUM_W-1:0];
        REG_HI_HUM: hi_hum_r <= pwdata[HUM_W-1:0];
        REG_LO_RAW: lo_raw_r <= pwdata[RAW_W-1:0];
        REG_HI_RAW: hi_raw_r <= pwdata[RAW_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_LO_HUM: prdata = 32'(lo_hum_r);
      REG_HI_HUM: prdata = 32'(hi_hum_r);
      REG_LO_RAW: prdata = 32'($unsigned(lo_raw_r));
      REG_HI_RAW: prdata = 32'($unsigned(hi_raw_r));
      default:    prdata = '0;
    endcase
  end

  // fully pipelined: never back-pressures
  assign busy    = 1'b0;
  assign in_xfer = start & ~busy;

  hca_front u_front (
    .clk   (clk),
    .rst_n (rst_n),
    .v_i   (in_xfer),
    .raw_i (in_raw_sample),
    .r0_i  (lo_raw_r),
    .r1_i  (hi_raw_r),
    .h0_i  (lo_hum_r),
    .h1_i  (hi_hum_r),
    .v_o   (fv),
    .d_o   (fd)
  );

  // quotient bits 8..6, 5..3, 2..0
  hca_div_step #(.HI(8), .NSTEP(3)) u_div_a (
    .clk(clk), .rst_n(rst_n), .v_i(fv),  .d_i(fd),  .v_o(v_a), .d_o(d_a)
  );
  hca_div_step #(.HI(5), .NSTEP(3)) u_div_b (
    .clk(clk), .rst_n(rst_n), .v_i(v_a), .d_i(d_a), .v_o(v_b), .d_o(d_b)
  );
  hca_div_step #(.HI(2), .NSTEP(3)) u_div_c (
    .clk(clk), .rst_n(rst_n), .v_i(v_b), .d_i(d_b), .v_o(v_c), .d_o(d_c)
  );

  hca_finish u_finish (
    .clk   (clk),
    .rst_n (rst_n),
    .v_i   (v_c),
    .d_i   (d_c),
    .v_o   (rv),
    .r_o   (rr)
  );

  assign out_valid             = rv;
  assign out_humidity_half_pct = rr.hum;
  assign out_digit_thousands   = rr.d_thou;
  assign out_digit_hundreds    = rr.d_hund;
  assign out_digit_tens        = rr.d_tens;
  assign out_digit_ones        = rr.d_ones;
  assign out_was_clamped       = rr.clamped;
  assign out_divide_error      = rr.dz;

endmodule

`default_nettype wire

// File: rtl/hca_front.sv
// ============================================================================
// hca_front: differences, multiply and magnitude split (three stages)
// Forms (raw - r0) * (h1 - h0) and r1 - r0, then hands magnitudes, signs and
// the range check to the divider.
// ============================================================================
`default_nettype none

module hca_front import hca_pkg::*; (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    v_i,
  input  wire logic signed [RAW_W-1:0] raw_i,
  input  wire logic signed [RAW_W-1:0] r0_i,
  input  wire logic signed [RAW_W-1:0] r1_i,
  input  wire logic        [HUM_W-1:0] h0_i,
  input  wire logic        [HUM_W-1:0] h1_i,
  output logic                         v_o,
  output div_t                         d_o
);

  localparam int CMP_W = MAG_W + 1;

  // stage 1
  logic                     v1_r;
  logic signed [DIFF_W-1:0] diff_r, diff_nxt;
  logic signed [DH_W-1:0]   dh_r, dh_nxt;
  logic signed [DIFF_W-1:0] den1_r, den1_nxt;
  logic        [HUM_W-1:0]  h01_r;

  // stage 2
  logic                     v2_r;
  logic signed [PROD_W-1:0] prod_r, prod_nxt;
  logic signed [DIFF_W-1:0] den2_r;
  logic        [HUM_W-1:0]  h02_r;

  // stage 3
  logic                     v3_r;
  div_t                     d3_r, d3_nxt;
  logic        [PROD_W-1:0] pmag;
  logic        [DIFF_W-1:0] dmag;

  always_comb begin
    diff_nxt = DIFF_W'(raw_i) - DIFF_W'(r0_i);
    dh_nxt   = $signed({1'b0, h1_i}) - $signed({1'b0, h0_i});
    den1_nxt = DIFF_W'(r1_i) - DIFF_W'(r0_i);
  end

  assign prod_nxt = diff_r * dh_r;

  always_comb begin
    pmag = prod_r[PROD_W-1] ? PROD_W'(-prod_r) : PROD_W'(prod_r);
    dmag = den2_r[DIFF_W-1] ? DIFF_W'(-den2_r) : DIFF_W'(den2_r);
    d3_nxt.rem     = pmag[MAG_W-1:0];
    d3_nxt.quo     = '0;
    d3_nxt.den_mag = dmag[DEN_W-1:0];
    d3_nxt.neg     = prod_r[PROD_W-1] ^ den2_r[DIFF_W-1];
    d3_nxt.ovf     = CMP_W'(pmag[MAG_W-1:0]) >= {dmag[DEN_W-1:0], {QBITS{1'b0}}};
    d3_nxt.dz      = (den2_r == '0);
    d3_nxt.h0      = h02_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v1_r <= v_i;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    diff_r <= diff_nxt;
    dh_r   <= dh_nxt;
    den1_r <= den1_nxt;
    h01_r  <= h0_i;
    prod_r <= prod_nxt;
    den2_r <= den1_r;
    h02_r  <= h01_r;
    d3_r   <= d3_nxt;
  end

  assign v_o = v3_r;
  assign d_o = d3_r;

endmodule

`default_nettype wire

// File: rtl/hca_div_step.sv
// ============================================================================
// hca_div_step: one registered slice of the restoring divider
// Resolves NSTEP quotient bits, from bit HI downward, per stage.
// ============================================================================
`default_nettype none

module hca_div_step import hca_pkg::*; #(
  parameter int HI    = 8,
  parameter int NSTEP = 3
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic v_i,
  input  div_t      d_i,
  output logic      v_o,
  output div_t      d_o
);

  localparam int EXT_W = MAG_W + 1;

  logic             v_r;
  div_t             d_r, d_nxt;
  logic [EXT_W-1:0] rem_w;
  logic [EXT_W-1:0] trial;
  logic [QBITS-1:0] quo_w;

  always_comb begin
    rem_w = {1'b0, d_i.rem};
    quo_w = d_i.quo;
    trial = '0;
    for (int i = 0; i < NSTEP; i++) begin
      trial = EXT_W'(d_i.den_mag) << (HI - i);
      if (rem_w >= trial) begin
        rem_w = rem_w - trial;
        quo_w = quo_w | (QBITS'(1) << (HI - i));
      end
    end
    d_nxt     = d_i;
    d_nxt.rem = rem_w[MAG_W-1:0];
    d_nxt.quo = quo_w;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else begin
      v_r <= v_i;
    end
  end

  always_ff @(posedge clk) begin
    d_r <= d_nxt;
  end

  assign v_o = v_r;
  assign d_o = d_r;

endmodule

`default_nettype wire

// File: rtl/hca_finish.sv
// ============================================================================
// hca_finish: sign, offset, clamp and ASCII digits (two stages)
// Applies the quotient sign, adds the low point, clamps to 0..200, then
// splits the clamped value into decimal digits.
// ============================================================================
`default_nettype none

module hca_finish import hca_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic v_i,
  input  div_t      d_i,
  output logic      v_o,
  output res_t      r_o
);

  localparam int SUM_W = QBITS + 2;

  logic                    v7_r;
  logic [HUM_W-1:0]        hum_r, hum_nxt;
  logic                    cl_r, cl_nxt;
  logic                    dz_r;
  logic signed [SUM_W-1:0] qs;
  logic signed [SUM_W-1:0] val;

  logic                    v8_r;
  res_t                    r8_r, r8_nxt;
  logic [1:0]              hund;
  logic [6:0]              rest;
  logic [14:0]             tprod;
  logic [3:0]              tens;
  logic [3:0]              ones;

  always_comb begin
    qs  = d_i.neg ? -$signed(SUM_W'(d_i.quo)) : $signed(SUM_W'(d_i.quo));
    val = qs + $signed(SUM_W'(d_i.h0));
    hum_nxt = '0;
    cl_nxt  = 1'b0;
    if (d_i.dz) begin
      hum_nxt = '0;
    end else if (d_i.ovf) begin
      cl_nxt  = 1'b1;
      hum_nxt = d_i.neg ? '0 : HUM_MAX;
    end else if (val < 0) begin
      cl_nxt  = 1'b1;
    end else if (val > $signed(SUM_W'(HUM_MAX))) begin
      cl_nxt  = 1'b1;
      hum_nxt = HUM_MAX;
    end else begin
      hum_nxt = val[HUM_W-1:0];
    end
  end

  // value is at most 200: hundreds by compare, tens by x205 >> 11
  always_comb begin
    if (hum_r >= 8'd200) begin
      hund = 2'd2;
      rest = 7'(hum_r - 8'd200);
    end else if (hum_r >= 8'd100) begin
      hund = 2'd1;
      rest = 7'(hum_r - 8'd100);
    end else begin
      hund = 2'd0;
      rest = hum_r[6:0];
    end
    tprod = 15'(rest) * 15'd205;
    tens  = tprod[14:11];
    ones  = 4'(rest - 7'(tens) * 7'd10);
    r8_nxt.hum     = hum_r;
    r8_nxt.d_thou  = ASCII_ZERO;
    r8_nxt.d_hund  = ASCII_ZERO + DIG_W'(hund);
    r8_nxt.d_tens  = ASCII_ZERO + DIG_W'(tens);
    r8_nxt.d_ones  = ASCII_ZERO + DIG_W'(ones);
    r8_nxt.clamped = cl_r;
    r8_nxt.dz      = dz_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v7_r <= 1'b0;
      v8_r <= 1'b0;
    end else begin
      v7_r <= v_i;
      v8_r <= v7_r;
    end
  end

  always_ff @(posedge clk) begin
    hum_r <= hum_nxt;
    cl_r  <= cl_nxt;
    dz_r  <= d_i.dz;
    r8_r  <= r8_nxt;
  end

  assign v_o = v8_r;
  assign r_o = r8_r;

endmodule

`default_nettype wire

// File: rtl/hca_checker.sv
// ============================================================================
// hca_checker: port-level checks for the humidity calibration block
// Latency, result range, digit agreement and the divide-error case.
// ============================================================================
`default_nettype none

module hca_checker import hca_pkg::*; (
  input wire logic             clk,
  input wire logic             rst_n,
  input wire logic             start,
  input wire logic             busy,
  input wire logic             out_valid,
  input wire logic [HUM_W-1:0] out_humidity_half_pct,
  input wire logic [DIG_W-1:0] out_digit_thousands,
  input wire logic [DIG_W-1:0] out_digit_hundreds,
  input wire logic [DIG_W-1:0] out_digit_tens,
  input wire logic [DIG_W-1:0] out_digit_ones,
  input wire logic             out_was_clamped,
  input wire logic             out_divide_error
);

  logic [9:0] dig_val;

  assign dig_val = 10'(out_digit_hundreds - ASCII_ZERO) * 10'd100
                 + 10'(out_digit_tens - ASCII_ZERO) * 10'd10
                 + 10'(out_digit_ones - ASCII_ZERO);

  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##LATENCY out_valid)
    else $error("result strobe missing after a sample transfer");

  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_humidity_half_pct <= HUM_MAX)
    else $error("humidity out of range");

  a_digits: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_digit_thousands == ASCII_ZERO
                   && dig_val == 10'(out_humidity_half_pct)))
    else $error("digits disagree with humidity value");

  a_diverr: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_divide_error) |->
      (out_humidity_half_pct == '0 && !out_was_clamped))
    else $error("divide error result not zero");

endmodule

bind humidity_calibrate_to_ascii hca_checker u_hca_checker (
  .clk                   (clk),
  .rst_n                 (rst_n),
  .start                 (start),
  .busy                  (busy),
  .out_valid             (out_valid),
  .out_humidity_half_pct (out_humidity_half_pct),
  .out_digit_thousands   (out_digit_thousands),
  .out_digit_hundreds    (out_digit_hundreds),
  .out_digit_tens        (out_digit_tens),
  .out_digit_ones        (out_digit_ones),
  .out_was_clamped       (out_was_clamped),
  .out_divide_error      (out_divide_error)
);

`default_nettype wire
